FILE: sv/lwt_pkg.sv
// ----------------------------------------------------------------------------
// lwt_pkg
// shared types and constants of the lock wait table with deadlock flag
// ----------------------------------------------------------------------------
package lwt_pkg;

  // field widths
  localparam int unsigned KEY_W   = 64;
  localparam int unsigned COUNT_W = 16;
  localparam int unsigned ENTRY_W = KEY_W + COUNT_W;

  // default table size
  localparam int unsigned DEF_TABLE_ENTRIES = 64;

  // count codes
  localparam logic [COUNT_W-1:0] COUNT_MIN  = {1'b1, {(COUNT_W-1){1'b0}}};
  localparam logic [COUNT_W-1:0] COUNT_ZERO = '0;
  localparam logic [COUNT_W-1:0] COUNT_NEG1 = '1;

  // commands
  localparam logic CMD_LOCK   = 1'b0;
  localparam logic CMD_UNLOCK = 1'b1;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_RESP
  } state_e;

  // one result item
  typedef struct packed {
    logic found;
    logic deadlock;
    logic table_full;
  } res_t;

endpackage

FILE: sv/lwt_mem.sv
// ----------------------------------------------------------------------------
// lwt_mem
// table memory: key and count per entry, one write and one registered read
// ----------------------------------------------------------------------------
module lwt_mem #(
  parameter int unsigned TABLE_ENTRIES = lwt_pkg::DEF_TABLE_ENTRIES,
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES)
) (
  input  logic                       clk_i,
  input  logic                       rd_en_i,
  input  logic [IDX_W-1:0]           rd_addr_i,
  output logic [lwt_pkg::ENTRY_W-1:0] rd_data_o,
  input  logic                       wr_en_i,
  input  logic [IDX_W-1:0]           wr_addr_i,
  input  logic [lwt_pkg::ENTRY_W-1:0] wr_data_i
);

  logic [lwt_pkg::ENTRY_W-1:0] mem_q [TABLE_ENTRIES];
  logic [lwt_pkg::ENTRY_W-1:0] rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // read port, registered
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: sv/lwt_ctrl.sv
// ----------------------------------------------------------------------------
// lwt_ctrl
// search sequencer: scans filled entries, updates the count or inserts a new entry, builds the result
// ----------------------------------------------------------------------------
module lwt_ctrl #(
  parameter int unsigned TABLE_ENTRIES = lwt_pkg::DEF_TABLE_ENTRIES,
  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES),
  localparam int unsigned CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input item
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        cmd_i,
  input  logic [lwt_pkg::KEY_W-1:0]   lock_id_i,
  // memory port
  output logic                        rd_en_o,
  output logic [IDX_W-1:0]            rd_addr_o,
  input  logic [lwt_pkg::ENTRY_W-1:0] rd_data_i,
  output logic                        wr_en_o,
  output logic [IDX_W-1:0]            wr_addr_o,
  output logic [lwt_pkg::ENTRY_W-1:0] wr_data_o,
  // result toward the output register
  output logic                        res_valid_o,
  output lwt_pkg::res_t               res_o,
  input  logic                        res_stall_i
);

  localparam logic [CNT_W-1:0] FULL_FILL = CNT_W'(TABLE_ENTRIES);

  lwt_pkg::state_e state_q, state_d;

  // control state
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] nonneg_q, nonneg_d;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic             pend_q, pend_d;
  logic             hit_q, hit_d;
  lwt_pkg::res_t    res_q, res_d;

  // item payload
  logic                        cmd_q, cmd_d;
  logic [lwt_pkg::KEY_W-1:0]   key_q, key_d;
  logic [IDX_W-1:0]            pend_idx_q, pend_idx_d;
  logic [IDX_W-1:0]            hit_idx_q, hit_idx_d;
  logic [lwt_pkg::COUNT_W-1:0] hit_cnt_q, hit_cnt_d;

  logic                        key_match;
  logic                        cnt_nonpos;

  assign key_match  = pend_q &&
                      (rd_data_i[lwt_pkg::ENTRY_W-1 -: lwt_pkg::KEY_W] == key_q);
  assign cnt_nonpos = hit_cnt_q[lwt_pkg::COUNT_W-1] || (hit_cnt_q == lwt_pkg::COUNT_ZERO);

  // next state, memory control and update
  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    nonneg_d   = nonneg_q;
    issue_d    = issue_q;
    pend_d     = 1'b0;
    hit_d      = hit_q;
    res_d      = res_q;
    cmd_d      = cmd_q;
    key_d      = key_q;
    pend_idx_d = pend_idx_q;
    hit_idx_d  = hit_idx_q;
    hit_cnt_d  = hit_cnt_q;
    rd_en_o    = 1'b0;
    rd_addr_o  = issue_q[IDX_W-1:0];
    wr_en_o    = 1'b0;
    wr_addr_o  = hit_idx_q;
    wr_data_o  = {key_q, hit_cnt_q};
    in_stall_o = 1'b1;
    res_valid_o = 1'b0;

    unique case (state_q)
      lwt_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_d   = cmd_i;
          key_d   = lock_id_i;
          issue_d = '0;
          hit_d   = 1'b0;
          state_d = lwt_pkg::ST_SCAN;
        end
      end

      lwt_pkg::ST_SCAN: begin
        priority if (key_match) begin
          // matching entry read back last cycle
          hit_d     = 1'b1;
          hit_idx_d = pend_idx_q;
          hit_cnt_d = rd_data_i[lwt_pkg::COUNT_W-1:0];
          state_d   = lwt_pkg::ST_UPDATE;
        end else if (issue_q < fill_q) begin
          // next filled entry
          rd_en_o    = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = issue_q[IDX_W-1:0];
          issue_d    = issue_q + CNT_W'(1);
        end else begin
          hit_d   = 1'b0;
          state_d = lwt_pkg::ST_UPDATE;
        end
      end

      lwt_pkg::ST_UPDATE: begin
        res_d.found      = hit_q;
        res_d.deadlock   = 1'b0;
        res_d.table_full = 1'b0;
        if (cmd_q == lwt_pkg::CMD_LOCK) begin
          if (hit_q) begin
            // decrement, saturating at the minimum
            if (hit_cnt_q != lwt_pkg::COUNT_MIN) begin
              wr_en_o   = 1'b1;
              wr_data_o = {key_q, hit_cnt_q - lwt_pkg::COUNT_W'(1)};
              if (hit_cnt_q == lwt_pkg::COUNT_ZERO && nonneg_q != '0) begin
                nonneg_d = nonneg_q - CNT_W'(1);
              end
            end
          end else if (fill_q != FULL_FILL) begin
            // insert at the lowest free entry
            wr_en_o   = 1'b1;
            wr_addr_o = fill_q[IDX_W-1:0];
            wr_data_o = {key_q, lwt_pkg::COUNT_ZERO};
            fill_d    = fill_q + CNT_W'(1);
            nonneg_d  = nonneg_q + CNT_W'(1);
          end else begin
            res_d.table_full = 1'b1;
          end
          res_d.deadlock = (nonneg_d == '0);
        end else if (hit_q && cnt_nonpos) begin
          // unlock increments only a held or waited lock
          wr_en_o   = 1'b1;
          wr_data_o = {key_q, hit_cnt_q + lwt_pkg::COUNT_W'(1)};
          if (hit_cnt_q == lwt_pkg::COUNT_NEG1) begin
            nonneg_d = nonneg_q + CNT_W'(1);
          end
        end
        state_d = lwt_pkg::ST_RESP;
      end

      lwt_pkg::ST_RESP: begin
        res_valid_o = 1'b1;
        if (!res_stall_i) begin
          state_d = lwt_pkg::ST_IDLE;
        end
      end

      default: state_d = lwt_pkg::ST_IDLE;
    endcase
  end

  assign res_o = res_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= lwt_pkg::ST_IDLE;
      fill_q   <= '0;
      nonneg_q <= '0;
      issue_q  <= '0;
      pend_q   <= 1'b0;
      hit_q    <= 1'b0;
      res_q    <= '0;
    end else begin
      state_q  <= state_d;
      fill_q   <= fill_d;
      nonneg_q <= nonneg_d;
      issue_q  <= issue_d;
      pend_q   <= pend_d;
      hit_q    <= hit_d;
      res_q    <= res_d;
    end
  end

  // item payload registers
  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    key_q      <= key_d;
    pend_idx_q <= pend_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_cnt_q  <= hit_cnt_d;
  end

endmodule

FILE: sv/lock_wait_table_deadlock_flag.sv
// ----------------------------------------------------------------------------
// lock_wait_table_deadlock_flag
// lock table with semaphore counts per identifier and a deadlock flag
// ----------------------------------------------------------------------------
//  channel | direction | handshake               | fields
//  --------+-----------+-------------------------+------------------------------
//  in      | input     | in_valid_i / in_stall_o | cmd_i, lock_id_i
//  out     | output    | out_valid_o/out_stall_i | found_o, deadlock_o,
//          |           |                         | table_full_o
//
//  one item at a time; an item waits on the search over the filled entries, up to
//  TABLE_ENTRIES, which runs over the single read port of the table
//  memory, one entry a cycle; a hit ends the search early.
//  reset empties the table at once through the fill count, no clearing pass.
//  a result waits in the output register while out_stall_i is high; the next
//  item is taken then, but its result waits until the register drains.
// ----------------------------------------------------------------------------
module lock_wait_table_deadlock_flag #(
  parameter int unsigned TABLE_ENTRIES = lwt_pkg::DEF_TABLE_ENTRIES
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      cmd_i,
  input  logic [lwt_pkg::KEY_W-1:0] lock_id_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic                      found_o,
  output logic                      deadlock_o,
  output logic                      table_full_o
);

  localparam int unsigned IDX_W = $clog2(TABLE_ENTRIES);

  logic                        rd_en;
  logic [IDX_W-1:0]            rd_addr;
  logic [lwt_pkg::ENTRY_W-1:0] rd_data;
  logic                        wr_en;
  logic [IDX_W-1:0]            wr_addr;
  logic [lwt_pkg::ENTRY_W-1:0] wr_data;

  logic          res_valid;
  logic          res_stall;
  lwt_pkg::res_t res;

  logic          out_valid_q;
  lwt_pkg::res_t out_q;

  // table memory
  lwt_mem #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_mem (
    .clk_i    (clk_i),
    .rd_en_i  (rd_en),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data),
    .wr_en_i  (wr_en),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data)
  );

  // search and update sequencer
  lwt_ctrl #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .cmd_i      (cmd_i),
    .lock_id_i  (lock_id_i),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_data_i  (rd_data),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .res_valid_o(res_valid),
    .res_o      (res),
    .res_stall_i(res_stall)
  );

  // output register
  assign res_stall = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && !res_stall) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && !res_stall) begin
      out_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign found_o      = out_q.found;
  assign deadlock_o   = out_q.deadlock;
  assign table_full_o = out_q.table_full;

`ifndef SYNTHESIS
  // one item in flight: the block is busy right after taking an item
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("item taken while previous item still in progress");

  // a result handed over shows up on the output
  a_result_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && !res_stall |=> out_valid_o)
    else $error("handed over result not presented");

  // a full table only arises for an unknown identifier
  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && table_full_o |-> !found_o)
    else $error("table_full reported for a known identifier");
`endif

endmodule
